// ----- rtl/toq_pkg.sv -----
// Shared constants, register codes and controller/datapath types of the occupancy qualifier.
`timescale 1ns / 1ps
package toq_pkg;

	localparam int CHANNELS    = 8;
	localparam int CH_W        = $clog2(CHANNELS);
	localparam int SAMPLE_BITS = 10;
	localparam int SAMPLE_W    = 10;
	localparam int CMP_W       = 16;
	localparam int CHAN_W      = 3;
	localparam int FLAG_W      = 8;
	localparam int HIST_W      = 8;
	localparam int CD_W        = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CMP_W-1:0] SAMPLE_MASK = CMP_W'((32'd1 << SAMPLE_BITS) - 32'd1);
	localparam logic [7:0]      THR_ON_MIN  = 8'd10;
	localparam logic [7:0]      THR_OFF_MIN = 8'd5;
	localparam logic [3:0]      AGREE_MIN   = 4'd1;
	localparam logic [3:0]      AGREE_MAX   = 4'd8;
	localparam logic [CD_W-1:0] DELAY_SCALE = CD_W'(10);
	localparam logic [CH_W-1:0] LAST_CH     = CH_W'(CHANNELS - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD_ON     = 3'd0,
		REG_THRESHOLD_OFF    = 3'd1,
		REG_MIN_SAMPLES      = 3'd2,
		REG_CHANNEL_DELAYS   = 3'd3,
		REG_SHARED_OFF_DELAY = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic            capture;
		logic            exec_sample;
		logic            tick_step;
		logic [CH_W-1:0] tick_idx;
		logic            load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic op_tick;
	} dp_status_t;

endpackage

// ----- rtl/toq_item_if.sv -----
// Input channel: converter samples and timer ticks.
`timescale 1ns / 1ps
interface toq_item_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [toq_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output op, output sample, input ready);
	modport sink (input valid, input op, input sample, output ready);
endinterface

// ----- rtl/toq_result_if.sv -----
// Result channel: sampled channel and the occupied and free flag vectors.
`timescale 1ns / 1ps
interface toq_result_if;
	logic                        valid;
	logic                        ready;
	logic [toq_pkg::CHAN_W-1:0]  channel;
	logic [toq_pkg::FLAG_W-1:0]  on_flags;
	logic [toq_pkg::FLAG_W-1:0]  off_flags;

	modport source (output valid, output channel, output on_flags, output off_flags,
		input ready);
	modport sink (input valid, input channel, input on_flags, input off_flags,
		output ready);
endinterface

// ----- rtl/toq_cfg_if.sv -----
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface toq_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [toq_pkg::CFG_IDX_W-1:0]  index;
	logic [toq_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/toq_ctrl.sv -----
// Controller state machine: input and result handshakes and the countdown sweep sequence.
`timescale 1ns / 1ps
module toq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  toq_pkg::dp_status_t status,
	output toq_pkg::dp_cmd_t    cmd
);
	import toq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FINISH
	} state_t;

	state_t          state_q;
	logic [CH_W-1:0] idx_q;
	logic            ready_q;
	logic            out_valid_q;
	logic            slot_free;

	assign in_ready  = ready_q;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd             = '0;
		cmd.tick_idx    = idx_q;
		cmd.capture     = (state_q == ST_IDLE) && in_valid && ready_q;
		cmd.exec_sample = (state_q == ST_EXEC) && !status.op_tick;
		cmd.tick_step   = (state_q == ST_EXEC) && status.op_tick;
		cmd.load_out    = (state_q == ST_FINISH) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The result register is loaded once the previous beat has gone.
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && ready_q) begin
						ready_q <= 1'b0;
						idx_q   <= '0;
						state_q <= ST_EXEC;
					end else begin
						ready_q <= 1'b1;
					end
				end
				ST_EXEC: begin
					if (!status.op_tick) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q <= idx_q + CH_W'(1);
						if (idx_q == LAST_CH) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/toq_dp.sv -----
// Datapath: configuration registers, per-channel history and countdowns, result register.
`timescale 1ns / 1ps
module toq_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  toq_pkg::dp_cmd_t              cmd,
	output toq_pkg::dp_status_t           status,
	input  logic                          item_op,
	input  logic [toq_pkg::SAMPLE_W-1:0]  item_sample,
	input  logic                          cfg_we,
	input  logic [toq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [toq_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [toq_pkg::CHAN_W-1:0]    res_channel,
	output logic [toq_pkg::FLAG_W-1:0]    res_on_flags,
	output logic [toq_pkg::FLAG_W-1:0]    res_off_flags
);
	import toq_pkg::*;

	logic [7:0]            thr_on_q;
	logic [7:0]            thr_off_q;
	logic [3:0]            min_samples_q;
	logic [CFG_DATA_W-1:0] delays_q;
	logic [7:0]            shared_delay_q;

	logic                  op_q;
	logic [SAMPLE_W-1:0]   sample_q;
	logic [CH_W-1:0]       cur_ch_q;
	logic [CH_W-1:0]       last_ch_q;
	logic [HIST_W-1:0]     history_q [CHANNELS];
	logic [CD_W-1:0]       countdown_q [CHANNELS];
	logic [CHANNELS-1:0]   on_bits_q;
	logic [CHANNELS-1:0]   off_bits_q;

	logic [CHAN_W-1:0]     res_channel_q;
	logic [FLAG_W-1:0]     res_on_q;
	logic [FLAG_W-1:0]     res_off_q;

	logic [CH_W-1:0]       rd_idx;
	logic [HIST_W-1:0]     hist_rd;
	logic [CD_W-1:0]       cd_rd;
	logic [CMP_W-1:0]      s_val;
	logic [CMP_W-1:0]      hi_val;
	logic [CMP_W-1:0]      lo_val;
	logic [3:0]            agree_n;
	logic [HIST_W-1:0]     agree_mask;
	logic [HIST_W-1:0]     hist_new;
	logic [HIST_W-1:0]     rel;
	logic                  stable_new;
	logic [7:0]            delay_byte;
	logic [CD_W-1:0]       reload;
	logic [CD_W-1:0]       cd_dec;

	assign status.op_tick = op_q;

	// Both the sample update and the sweep use one read address into the per-channel state.
	assign rd_idx  = cmd.tick_step ? cmd.tick_idx : cur_ch_q;
	assign hist_rd = history_q[rd_idx];
	assign cd_rd   = countdown_q[rd_idx];

	always_comb begin
		s_val   = CMP_W'(sample_q) & SAMPLE_MASK;
		hi_val  = CMP_W'((thr_on_q < THR_ON_MIN) ? THR_ON_MIN : thr_on_q);
		lo_val  = CMP_W'((thr_off_q < THR_OFF_MIN) ? THR_OFF_MIN : thr_off_q);
		agree_n = min_samples_q;
		if (agree_n < AGREE_MIN) begin
			agree_n = AGREE_MIN;
		end else if (agree_n > AGREE_MAX) begin
			agree_n = AGREE_MAX;
		end
		agree_mask = HIST_W'((9'd1 << agree_n) - 9'd1);

		// The upper test wins when the thresholds cross.
		if (s_val > hi_val) begin
			hist_new = {hist_rd[HIST_W-2:0], 1'b1};
		end else if (s_val < lo_val) begin
			hist_new = {hist_rd[HIST_W-2:0], 1'b0};
		end else begin
			hist_new = hist_rd;
		end
		rel        = hist_new & agree_mask;
		stable_new = (rel == agree_mask);

		delay_byte = delays_q[8*rd_idx +: 8];
		reload     = (delay_byte == 8'd0) ? CD_W'(shared_delay_q) * DELAY_SCALE
			: CD_W'(delay_byte);
		cd_dec     = (cd_rd != '0) ? cd_rd - CD_W'(1) : cd_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_on_q       <= THR_ON_MIN;
			thr_off_q      <= THR_OFF_MIN;
			min_samples_q  <= AGREE_MIN;
			delays_q       <= '0;
			shared_delay_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD_ON:     thr_on_q       <= cfg_data[7:0];
				REG_THRESHOLD_OFF:    thr_off_q      <= cfg_data[7:0];
				REG_MIN_SAMPLES:      min_samples_q  <= cfg_data[3:0];
				REG_CHANNEL_DELAYS:   delays_q       <= cfg_data;
				REG_SHARED_OFF_DELAY: shared_delay_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= 1'b0;
			cur_ch_q    <= '0;
			last_ch_q   <= '0;
			on_bits_q   <= '0;
			off_bits_q  <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				history_q[i]   <= '0;
				countdown_q[i] <= '0;
			end
		end else begin
			if (cmd.capture) begin
				op_q <= item_op;
			end
			if (cmd.exec_sample) begin
				history_q[rd_idx]   <= hist_new;
				on_bits_q[rd_idx]   <= hist_new[0] & stable_new;
				if (!stable_new && rel != '0) begin
					countdown_q[rd_idx] <= reload;
				end
				last_ch_q <= cur_ch_q;
				cur_ch_q  <= (cur_ch_q == LAST_CH) ? '0 : cur_ch_q + CH_W'(1);
			end
			if (cmd.tick_step) begin
				countdown_q[rd_idx] <= cd_dec;
				off_bits_q[rd_idx]  <= (cd_dec == '0) && !hist_rd[0];
			end
		end
	end

	// Payload registers of the item and the result beat need no reset.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= item_sample;
		end
		if (cmd.load_out) begin
			res_channel_q <= op_q ? '0 : CHAN_W'(last_ch_q);
			res_on_q      <= FLAG_W'(on_bits_q);
			res_off_q     <= FLAG_W'(off_bits_q);
		end
	end

	assign res_channel   = res_channel_q;
	assign res_on_flags  = res_on_q;
	assign res_off_flags = res_off_q;

endmodule

// ----- rtl/track_occupancy_qualifier.sv -----
// Top level of the eight-channel track occupancy qualifier.
`timescale 1ns / 1ps
// Each accepted beat on item is either a converter sample for the current round-robin
// channel (op 0) or a timer tick (op 1), and gives exactly one result beat. A sample
// passes from ST_EXEC to ST_FINISH, where its result is loaded; a tick stays in ST_EXEC
// while it sweeps the off countdowns of all CHANNELS channels through the one shared
// decrement unit, one channel a cycle. One item is in work at a time: item.ready rises again
// in the cycle after the result is loaded, and a result still waiting on result.ready holds
// back only the next result, not the next acceptance. Configuration writes are always
// accepted and should be made only while the block is idle.
module track_occupancy_qualifier (
	input  logic          clk,
	input  logic          arst_n,
	toq_item_if.sink      item,
	toq_result_if.source  result,
	toq_cfg_if.sink       cfg
);
	import toq_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg.ready = 1'b1;

	toq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	toq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.item_op       (item.op),
		.item_sample   (item.sample),
		.cfg_we        (cfg.valid && cfg.ready),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.res_channel   (result.channel),
		.res_on_flags  (result.on_flags),
		.res_off_flags (result.off_flags)
	);

`ifndef SYNTHESIS
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.exec_sample, cmd.tick_step, cmd.load_out}))
		else $error("more than one datapath command in a cycle");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("second item accepted while one is in work");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_step |-> cmd.tick_idx <= LAST_CH)
		else $error("countdown sweep beyond the last channel");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!result.valid || result.ready))
		else $error("result register loaded over a waiting beat");
`endif

endmodule
